>>> rtl/frame_builder_crc16_macros.svh
// ----------------------------------------------------------------------------
// frame_builder_crc16 assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef FRAME_BUILDER_CRC16_MACROS_SVH
`define FRAME_BUILDER_CRC16_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("frame_builder_crc16 check failed");
// condition must never be seen at a clock edge out of reset
`define FBC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("frame_builder_crc16 forbidden condition");
`else
`define FBC_ASSERT(lbl, clk, rstn, prop)
`define FBC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types, constants and the crc-16/xmodem byte update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int QUEUE_DEPTH = 6;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  NON_PAYLOAD_LEN = 8'd5;
  localparam logic [7:0]  MAX_PAYLOAD     = 8'd250;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_INIT        = 16'h0000;

  typedef logic [7:0] byte_t;

  typedef enum logic {
    REG_HEADER = 1'b0,
    REG_TAIL   = 1'b1
  } reg_idx_t;

  // words handed from the frame logic to the output queue in one go
  typedef struct packed {
    logic [QCNT_W-1:0]                num;
    logic [QUEUE_DEPTH-1:0][7:0]      data;
    logic [QUEUE_DEPTH-1:0]           last;
  } load_t;

  typedef struct packed {
    logic       in_frame;
    logic [7:0] bytes_left;
  } ctl_status_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  // one byte into the crc, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/fbc_frame_ctl.sv
// ----------------------------------------------------------------------------
// fbc_frame_ctl
// frame state, running crc and the set of words each input byte causes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_frame_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  fbc_pkg::byte_t      data_byte,
  input  fbc_pkg::byte_t      data_count,
  input  fbc_pkg::byte_t      header,
  input  fbc_pkg::byte_t      tail,
  input  logic [15:0]         hdr_crc,
  output fbc_pkg::load_t      load,
  output fbc_pkg::ctl_status_t status
);
  import fbc_pkg::*;

  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic        start, drop, close;
  logic [7:0]  len_byte;
  logic [7:0]  left_after;
  logic [15:0] crc_base;
  logic [15:0] crc_after;

  assign start      = !in_frame_r;
  assign drop       = start && ((data_count == 8'd0) || (data_count > MAX_PAYLOAD));
  assign len_byte   = data_count + NON_PAYLOAD_LEN;
  assign left_after = start ? (data_count - 8'd1) : (left_r - 8'd1);
  assign close      = (left_after == 8'd0);
  // header crc is precomputed at config time
  assign crc_base   = start ? crc_feed(hdr_crc, len_byte) : crc_r;
  assign crc_after  = crc_feed(crc_base, data_byte);

  always_comb begin
    load = '0;
    if (drop) begin
      load.num = '0;
    end else if (start && close) begin
      load.num     = QCNT_W'(6);
      load.data[0] = header;
      load.data[1] = len_byte;
      load.data[2] = data_byte;
      load.data[3] = crc_after[15:8];
      load.data[4] = crc_after[7:0];
      load.data[5] = tail;
      load.last[5] = 1'b1;
    end else if (start) begin
      load.num     = QCNT_W'(3);
      load.data[0] = header;
      load.data[1] = len_byte;
      load.data[2] = data_byte;
    end else if (close) begin
      load.num     = QCNT_W'(4);
      load.data[0] = data_byte;
      load.data[1] = crc_after[15:8];
      load.data[2] = crc_after[7:0];
      load.data[3] = tail;
      load.last[3] = 1'b1;
    end else begin
      load.num     = QCNT_W'(1);
      load.data[0] = data_byte;
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    left_nxt     = left_r;
    crc_nxt      = crc_r;
    if (take && !drop) begin
      if (close) begin
        in_frame_nxt = 1'b0;
        left_nxt     = 8'd0;
        crc_nxt      = CRC_INIT;
      end else begin
        in_frame_nxt = 1'b1;
        left_nxt     = left_after;
        crc_nxt      = crc_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      left_r     <= 8'd0;
      crc_r      <= CRC_INIT;
    end else begin
      in_frame_r <= in_frame_nxt;
      left_r     <= left_nxt;
      crc_r      <= crc_nxt;
    end
  end

  assign status.in_frame   = in_frame_r;
  assign status.bytes_left = left_r;

endmodule

>>> rtl/fbc_out_queue.sv
// ----------------------------------------------------------------------------
// fbc_out_queue
// six-word result register, loaded at once, drained one word a cycle if ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_en,
  input  fbc_pkg::load_t         load,
  output logic                   can_load,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output fbc_pkg::byte_t         out_byte,
  output logic                   out_last,
  output fbc_pkg::queue_status_t status
);
  import fbc_pkg::*;

  logic [QCNT_W-1:0]           cnt_r, cnt_nxt;
  logic [QUEUE_DEPTH-1:0][7:0] data_r;
  logic [QUEUE_DEPTH-1:0]      last_r;
  logic                        pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  // take a new load when empty or when the final word leaves this cycle
  assign can_load   = (cnt_r == '0) || ((cnt_r == QCNT_W'(1)) && out_tready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load_en) begin
      cnt_nxt = load.num;
    end else if (pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load.data;
      last_r <= load.last;
    end else if (pop) begin
      data_r <= data_r >> 8;
      last_r <= last_r >> 1;
    end
  end

  assign out_byte     = data_r[0];
  assign out_last     = last_r[0];
  assign status.count = cnt_r;

endmodule

>>> rtl/frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// frame_builder_crc16
// byte framer: header, length, payload, crc-16/xmodem (hi, lo), tail
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  ---------+-----------+--------------------------------------------------
//  in_*     | slave     | tdata[7:0] data_byte, tdata[15:8] data_count
//  out_*    | master    | tdata[7:0] out_byte, tlast = frame_end
//  cfg_*    | write     | addr 0 header_value, addr 1 tail_value
//
//  one input word per cycle inside a frame while out_tready holds; each word
//  is decided in the cycle it is accepted and its output words land in a
//  six-word register; the output side drains one word a cycle while ready,
//  so the input stalls while a frame's header, crc and tail words are sent
//  a new word is taken while the last queued word is being handed out
//  dropped words (count 0 or above 250 when idle) are taken but queue nothing
//  reset is synchronous on rst_n low; it clears frame state and registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_builder_crc16_macros.svh"

module frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] data_byte, [15:8] data_count
  // framed output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,   // frame_end, set on the tail byte
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import fbc_pkg::*;

  byte_t         header_r;
  byte_t         tail_r;
  logic [15:0]   hdr_crc_r;       // crc of the header byte alone

  logic          take;
  load_t         load;
  ctl_status_t   ctl_st;
  queue_status_t q_st;

  // config registers; header crc follows the header so the first
  // payload byte only has two crc steps in its path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= 8'd0;
      tail_r    <= 8'd0;
      hdr_crc_r <= crc_feed(CRC_INIT, 8'd0);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_HEADER: begin
          header_r  <= cfg_wdata;
          hdr_crc_r <= crc_feed(CRC_INIT, cfg_wdata);
        end
        REG_TAIL: begin
          tail_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign take = in_tvalid && in_tready;

  // frame state and word selection
  fbc_frame_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_tdata[7:0]),
    .data_count (in_tdata[15:8]),
    .header     (header_r),
    .tail       (tail_r),
    .hdr_crc    (hdr_crc_r),
    .load       (load),
    .status     (ctl_st)
  );

  // result register, drained one word per cycle while out_tready is high
  fbc_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (take),
    .load       (load),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .status     (q_st)
  );

  // ---- checks ----
  // tail is always the final queued word
  `FBC_ASSERT(a_tail_last, clk, rst_n, (out_tvalid && out_tlast) |-> (q_st.count == QCNT_W'(1)))
  // input only opens when at most one word is left to send
  `FBC_ASSERT(a_ready_room, clk, rst_n, in_tready |-> (q_st.count <= QCNT_W'(1)))
  // an open frame always expects more payload
  `FBC_ASSERT_NEVER(a_open_empty, clk, rst_n, ctl_st.in_frame && (ctl_st.bytes_left == 8'd0))
  // queue count never exceeds its depth of six words
  `FBC_ASSERT_NEVER(a_q_over, clk, rst_n, q_st.count > QCNT_W'(QUEUE_DEPTH))

endmodule
